/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL of the OSC parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define OSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be true outside reset.
`define OSP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/osp_pkg.sv */
// ----------------------------------------------------------------------------
// osp_pkg
// Shared types and constants of the OSC message stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package osp_pkg;

    // Sizes
    localparam int MAX_TAGS_DEF = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DATA_W       = 8;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;

    // Characters with a meaning in the stream
    localparam logic [DATA_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [DATA_W-1:0] CH_INT   = 8'h69;
    localparam logic [DATA_W-1:0] CH_FLOAT = 8'h66;
    localparam logic [DATA_W-1:0] CH_STR   = 8'h73;

    // Parser section
    typedef enum logic [1:0] {
        SEC_ADDR,
        SEC_TAGS,
        SEC_ARGS,
        SEC_DONE
    } section_t;

    // Stored type tag code
    typedef enum logic [1:0] {
        TAG_INT,
        TAG_FLOAT,
        TAG_STR,
        TAG_UNKNOWN
    } tag_code_t;

    // Result kind
    typedef enum logic [2:0] {
        KIND_ADDR_CHAR = 3'd0,
        KIND_TAG_CHAR  = 3'd1,
        KIND_INT       = 3'd2,
        KIND_FLOAT     = 3'd3,
        KIND_STR_CHAR  = 3'd4,
        KIND_STR_END   = 3'd5,
        KIND_MSG_END   = 3'd6
    } kind_t;

    // End-of-message status
    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_OVERFLOW,
        ST_UNKNOWN
    } status_t;

    // Classified byte request between front and back
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              fin;
        logic              is_nul;
        logic              is_comma;
        tag_code_t         tag_code;
    } req_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One result item
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        status_t            status;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

/* src/osc_message_stream_parser_core.sv */
// A byte accepted into the request queue has its first result registered at the output.
// Throughput: one byte per cycle while the two-entry queue has room; a final byte that
//   also yields a data result holds its message end in a second slot behind it.
// Back part takes one request per cycle if its output is free; the queue decouples it.
// Reset (rst_n, asynchronous, active low) clears parser state, queue and output
//   valid; the tag store holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// osc_message_stream_parser_core
// OSC message byte-stream parser: address, type tags and argument words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module osc_message_stream_parser_core
    import osp_pkg::*;
#(
    parameter int MAX_TAGS = MAX_TAGS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire logic [DATA_W-1:0]  data_byte,
    input  wire logic               final_byte,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [2:0]              kind,
    output logic [VALUE_W-1:0]      value,
    output logic [POS_W-1:0]        tag_position,
    output logic [1:0]              status,
    output logic                    last_of_run
);

    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    req_t      q_wdata;
    req_t      q_rdata;
    res_t      result;

    // Classify incoming bytes
    osp_front u_front (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // Request queue
    osp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // Parser and result output
    osp_back #(
        .MAX_TAGS (MAX_TAGS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign kind         = result.kind;
    assign value        = result.value;
    assign tag_position = result.pos;
    assign status       = result.status;
    assign last_of_run  = result.last;

    // Checks
    `OSP_ASSERT_NEVER(a_no_push_full, clk, rst_n, q_push && q_stat.full,
        "request pushed into a full queue")
    `OSP_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_stat.empty,
        "request popped from an empty queue")
    `OSP_ASSERT(a_end_is_last, clk, rst_n,
        (result_valid && kind == KIND_MSG_END) |-> last_of_run,
        "message end not marked as last result")
    `OSP_ASSERT(a_status_on_end, clk, rst_n,
        (result_valid && kind != KIND_MSG_END) |-> (status == ST_OK),
        "status set on a result other than message end")

endmodule

`default_nettype wire

/* src/osp_ram.sv */
// ----------------------------------------------------------------------------
// osp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/osp_front.sv */
// ----------------------------------------------------------------------------
// osp_front
// Input side: takes bytes and classifies them into requests for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_front
    import osp_pkg::*;
(
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire logic              final_byte,
    input  wire q_status_t         q_stat,
    output logic                   q_push,
    output req_t                   q_wdata
);

    tag_code_t code;

    // Accept whenever the queue has room
    assign byte_ready = !q_stat.full;
    assign q_push     = byte_valid && !q_stat.full;

    // Type tag decode
    always_comb
    begin
        case (data_byte)
            CH_INT:   code = TAG_INT;
            CH_FLOAT: code = TAG_FLOAT;
            CH_STR:   code = TAG_STR;
            default:  code = TAG_UNKNOWN;
        endcase
    end

    // Request payload
    always_comb
    begin
        q_wdata.data     = data_byte;
        q_wdata.fin      = final_byte;
        q_wdata.is_nul   = (data_byte == '0);
        q_wdata.is_comma = (data_byte == CH_COMMA);
        q_wdata.tag_code = code;
    end

endmodule

`default_nettype wire

/* src/osp_queue.sv */
// ----------------------------------------------------------------------------
// osp_queue
// Short register queue of classified byte requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_queue
    import osp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t wdata,
    input  wire logic pop,
    output req_t      rdata,
    output q_status_t stat
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    req_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* src/osp_back.sv */
// ----------------------------------------------------------------------------
// osp_back
// Parser state and result generation: one request per cycle into the output
// register while it is free, with a second slot for the message-end result.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_back
    import osp_pkg::*;
#(
    parameter int MAX_TAGS = MAX_TAGS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_stat,
    input  wire req_t      q_rdata,
    output logic           q_pop,
    output logic           result_valid,
    input  wire logic      result_ready,
    output res_t           result
);

    localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int CW = $clog2(MAX_TAGS + 1);

    // Parser state
    section_t        section_reg,  section_next;
    logic [1:0]      byte_pos_reg, byte_pos_next;
    logic [CW-1:0]   tag_count_reg, tag_count_next;
    logic [CW-1:0]   cur_tag_reg,  cur_tag_next;
    tag_code_t       cur_code_reg, cur_code_next;
    logic [23:0]     word_reg,     word_next;
    logic [1:0]      held_reg,     held_next;
    logic            pad_reg,      pad_next;
    status_t         err_reg,      err_next;

    // Output register and message-end slot
    logic            out_valid_reg,  out_valid_next;
    res_t            out_reg,        out_next;
    logic            pend_valid_reg, pend_valid_next;
    res_t            pend_reg,       pend_next;

    // Per-request values
    logic            process;
    logic            slot_free;
    logic            advance;
    logic [CW-1:0]   cur_inc;
    logic            tag_room;
    section_t        sec_step;
    status_t         err_step;
    logic [CW-1:0]   tcount_step;
    logic            res0_valid;
    res_t            res0;
    res_t            end_res;

    // Tag store
    logic            tag_wr_en;
    logic [AW-1:0]   tag_rd_addr;
    logic [1:0]      tag_rd_data;
    tag_code_t       next_code;

    // Read port always looks one tag ahead of the current one
    assign tag_rd_addr = AW'(cur_tag_next + CW'(1));
    assign next_code   = tag_code_t'(tag_rd_data);

    osp_ram #(
        .WIDTH (2),
        .DEPTH (MAX_TAGS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (AW'(tag_count_reg)),
        .wr_data (q_rdata.tag_code),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    // Handshake with queue and output
    assign slot_free = !out_valid_reg || result_ready;
    assign process   = !q_stat.empty && slot_free && !pend_valid_reg;
    assign q_pop     = process;
    assign cur_inc   = cur_tag_reg + CW'(1);
    assign tag_room  = (tag_count_reg < CW'(MAX_TAGS));

    // Next parser state
    always_comb
    begin
        section_next   = section_reg;
        byte_pos_next  = byte_pos_reg;
        tag_count_next = tag_count_reg;
        cur_tag_next   = cur_tag_reg;
        cur_code_next  = cur_code_reg;
        word_next      = word_reg;
        held_next      = held_reg;
        pad_next       = pad_reg;
        err_next       = err_reg;
        tag_wr_en      = 1'b0;
        advance        = 1'b0;

        if (process)
        begin
            byte_pos_next = byte_pos_reg + 2'd1;
            case (section_reg)
                SEC_ADDR:
                begin
                    if (q_rdata.is_comma)
                    begin
                        section_next = SEC_TAGS;
                    end
                end
                SEC_TAGS:
                begin
                    if (!q_rdata.is_nul)
                    begin
                        if (tag_room)
                        begin
                            tag_wr_en      = 1'b1;
                            tag_count_next = tag_count_reg + CW'(1);
                            // first tag is kept at hand for the section switch
                            if (tag_count_reg == '0)
                            begin
                                cur_code_next = q_rdata.tag_code;
                            end
                        end
                        else if (err_reg == ST_OK)
                        begin
                            err_next = ST_OVERFLOW;
                        end
                    end
                    else if (byte_pos_reg == 2'd3)
                    begin
                        if (tag_count_reg == '0)
                        begin
                            section_next = SEC_DONE;
                        end
                        else if (cur_code_reg == TAG_UNKNOWN)
                        begin
                            section_next = SEC_DONE;
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_UNKNOWN;
                            end
                        end
                        else
                        begin
                            section_next = SEC_ARGS;
                        end
                    end
                end
                SEC_ARGS:
                begin
                    case (cur_code_reg)
                        TAG_INT, TAG_FLOAT:
                        begin
                            if (held_reg == 2'd3)
                            begin
                                word_next = '0;
                                held_next = '0;
                                advance   = 1'b1;
                            end
                            else
                            begin
                                word_next = {word_reg[15:0], q_rdata.data};
                                held_next = held_reg + 2'd1;
                            end
                        end
                        TAG_STR:
                        begin
                            if (pad_reg)
                            begin
                                if (byte_pos_reg == 2'd3)
                                begin
                                    pad_next = 1'b0;
                                    advance  = 1'b1;
                                end
                            end
                            else if (q_rdata.is_nul)
                            begin
                                if (byte_pos_reg == 2'd3)
                                begin
                                    advance = 1'b1;
                                end
                                else
                                begin
                                    pad_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            // Move to the next argument and check it
            if (advance)
            begin
                cur_tag_next = cur_inc;
                if (cur_inc >= tag_count_reg)
                begin
                    section_next = SEC_DONE;
                end
                else if (next_code == TAG_UNKNOWN)
                begin
                    section_next = SEC_DONE;
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_UNKNOWN;
                    end
                end
                else
                begin
                    cur_code_next = next_code;
                end
            end
        end

        sec_step    = section_next;
        err_step    = err_next;
        tcount_step = tag_count_next;

        // Packet end returns to the start state
        if (process && q_rdata.fin)
        begin
            section_next   = SEC_ADDR;
            byte_pos_next  = '0;
            tag_count_next = '0;
            cur_tag_next   = '0;
            word_next      = '0;
            held_next      = '0;
            pad_next       = 1'b0;
            err_next       = ST_OK;
        end
    end

    // Result produced by the current request
    always_comb
    begin
        res0_valid  = 1'b0;
        res0.kind   = KIND_ADDR_CHAR;
        res0.value  = {{(VALUE_W - DATA_W){1'b0}}, q_rdata.data};
        res0.pos    = '0;
        res0.status = ST_OK;
        res0.last   = !q_rdata.fin;

        case (section_reg)
            SEC_ADDR:
            begin
                res0_valid = !q_rdata.is_comma && !q_rdata.is_nul;
            end
            SEC_TAGS:
            begin
                res0_valid = !q_rdata.is_nul && tag_room;
                res0.kind  = KIND_TAG_CHAR;
                res0.pos   = POS_W'(tag_count_reg);
            end
            SEC_ARGS:
            begin
                res0.pos = POS_W'(cur_tag_reg);
                case (cur_code_reg)
                    TAG_INT, TAG_FLOAT:
                    begin
                        res0_valid = (held_reg == 2'd3);
                        res0.kind  = (cur_code_reg == TAG_FLOAT) ? KIND_FLOAT : KIND_INT;
                        res0.value = {word_reg, q_rdata.data};
                    end
                    TAG_STR:
                    begin
                        res0_valid = !pad_reg;
                        if (q_rdata.is_nul)
                        begin
                            res0.kind  = KIND_STR_END;
                            res0.value = '0;
                        end
                        else
                        begin
                            res0.kind = KIND_STR_CHAR;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // Message end, reported from the state after this byte
        end_res.kind  = KIND_MSG_END;
        end_res.value = '0;
        end_res.pos   = POS_W'(tcount_step);
        end_res.last  = 1'b1;
        if (err_step == ST_OK && (sec_step inside {SEC_TAGS, SEC_ARGS}))
        begin
            end_res.status = ST_TRUNC;
        end
        else
        begin
            end_res.status = err_step;
        end
    end

    // Output register and message-end slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (pend_valid_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        else if (process && res0_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res0;
            if (q_rdata.fin)
            begin
                pend_valid_next = 1'b1;
                pend_next       = end_res;
            end
        end
        else if (process && q_rdata.fin)
        begin
            out_valid_next = 1'b1;
            out_next       = end_res;
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg    <= SEC_ADDR;
            byte_pos_reg   <= '0;
            tag_count_reg  <= '0;
            cur_tag_reg    <= '0;
            cur_code_reg   <= TAG_INT;
            word_reg       <= '0;
            held_reg       <= '0;
            pad_reg        <= 1'b0;
            err_reg        <= ST_OK;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            section_reg    <= section_next;
            byte_pos_reg   <= byte_pos_next;
            tag_count_reg  <= tag_count_next;
            cur_tag_reg    <= cur_tag_next;
            cur_code_reg   <= cur_code_next;
            word_reg       <= word_next;
            held_reg       <= held_next;
            pad_reg        <= pad_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
